>>> hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes of the sorted key table
// Request and result payloads, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int KEY_W        = 64;

	localparam logic [2:0] OP_LOOKUP = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;
	localparam logic [2:0] OP_LOAD   = 3'd5;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_MISS = 3'd1;
	localparam logic [2:0] ST_DUP  = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_BAD  = 3'd4;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [KEY_W-1:0] key;
		logic [7:0]       index;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [7:0]       position;
		logic [KEY_W-1:0] key_out;
		logic [8:0]       entry_total;
	} res_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_ROTATE,
		CM_INSERT,
		CM_REMOVE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t       mode;
		logic [KEY_W-1:0] new_key;
	} cell_cmd_t;

endpackage

>>> hw/rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the key ring
// Holds one key and takes its neighbor's key when the ring rotates or shifts.
// ----------------------------------------------------------------------------
module skt_cell #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
	parameter int INDEX    = 0,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                     clk,
	input  skt_pkg::cell_cmd_t       cmd,
	input  logic [AW-1:0]            pos,
	input  logic [skt_pkg::KEY_W-1:0] left_key,
	input  logic [skt_pkg::KEY_W-1:0] right_key,
	output logic [skt_pkg::KEY_W-1:0] key
);

	localparam logic [AW-1:0] MY_POS = AW'(INDEX);

	logic [skt_pkg::KEY_W-1:0] key_q;

	always_ff @(posedge clk) begin
		case (cmd.mode)
			skt_pkg::CM_ROTATE: begin
				key_q <= right_key;
			end
			skt_pkg::CM_INSERT: begin
				if (MY_POS == pos) begin
					key_q <= cmd.new_key;
				end else if (MY_POS > pos) begin
					key_q <= left_key;
				end
			end
			skt_pkg::CM_REMOVE: begin
				if (MY_POS >= pos) begin
					key_q <= right_key;
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	assign key = key_q;

endmodule

>>> hw/rtl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl: sequencer of the sorted key table
// Scans the rotating ring, replays the binary search and drives the shifts.
// ----------------------------------------------------------------------------
module skt_ctrl #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  skt_pkg::req_t             req,
	output logic                      res_valid,
	input  logic                      res_ready,
	output skt_pkg::res_t             res,
	input  logic [skt_pkg::KEY_W-1:0] head_key,
	output skt_pkg::cell_cmd_t        cmd,
	output logic [AW-1:0]             cmd_pos
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [CW-1:0] LAST_C = CW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_SEARCH,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t                    state_q;
	logic [2:0]                op_q;
	logic [skt_pkg::KEY_W-1:0] key_q;
	logic [7:0]                idx_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             scan_q;
	logic [CW-1:0]             lt_q;
	logic [CW-1:0]             le_q;
	logic [CW-1:0]             lo_q;
	logic [CW-1:0]             hi_q;
	logic [AW-1:0]             pos_q;
	logic [skt_pkg::KEY_W-1:0] rkey_q;
	logic [2:0]                status_q;
	skt_pkg::res_t             res_q;
	logic                      res_valid_q;
	logic [CW-1:0]             mid;
	logic                      zero_key;
	logic                      in_range;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign zero_key = (req.key == '0);
	assign in_range = RW'(req.index) < RW'(count_q);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		cmd.new_key = key_q;
		cmd_pos     = pos_q;
		case (state_q)
			S_SCAN: begin
				cmd.mode = skt_pkg::CM_ROTATE;
			end
			S_SHIFT: begin
				cmd.mode = (op_q == skt_pkg::OP_REMOVE) ? skt_pkg::CM_REMOVE
					: skt_pkg::CM_INSERT;
			end
			default: begin
				cmd.mode = skt_pkg::CM_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && (state_q != S_RESP)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q   <= req.opcode;
						key_q  <= req.key;
						idx_q  <= req.index;
						scan_q <= '0;
						lt_q   <= '0;
						le_q   <= '0;
						pos_q  <= '0;
						rkey_q <= '0;
						case (req.opcode)
							skt_pkg::OP_LOOKUP, skt_pkg::OP_REMOVE: begin
								if (zero_key) begin
									status_q <= skt_pkg::ST_BAD;
									state_q  <= S_RESP;
								end else begin
									status_q <= skt_pkg::ST_OK;
									state_q  <= S_SCAN;
								end
							end
							skt_pkg::OP_INSERT, skt_pkg::OP_LOAD: begin
								if (zero_key) begin
									status_q <= skt_pkg::ST_BAD;
									state_q  <= S_RESP;
								end else if (count_q >= CAP_C) begin
									status_q <= skt_pkg::ST_FULL;
									state_q  <= S_RESP;
								end else begin
									status_q <= skt_pkg::ST_OK;
									state_q  <= S_SCAN;
								end
							end
							skt_pkg::OP_READ: begin
								if (in_range) begin
									status_q <= skt_pkg::ST_OK;
									state_q  <= S_SCAN;
								end else begin
									status_q <= skt_pkg::ST_MISS;
									state_q  <= S_RESP;
								end
							end
							skt_pkg::OP_CLEAR: begin
								count_q  <= '0;
								status_q <= skt_pkg::ST_OK;
								state_q  <= S_RESP;
							end
							default: begin
								status_q <= skt_pkg::ST_MISS;
								state_q  <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_q < count_q) begin
						if (head_key < key_q) begin
							lt_q <= lt_q + 1'b1;
						end
						if (head_key <= key_q) begin
							le_q <= le_q + 1'b1;
						end
					end
					if (RW'(scan_q) == RW'(idx_q)) begin
						rkey_q <= head_key;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == LAST_C) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					lo_q <= '0;
					hi_q <= count_q;
					case (op_q)
						skt_pkg::OP_LOOKUP, skt_pkg::OP_REMOVE: begin
							rkey_q  <= '0;
							state_q <= S_SEARCH;
						end
						skt_pkg::OP_INSERT: begin
							if (le_q > lt_q) begin
								status_q <= skt_pkg::ST_DUP;
								rkey_q   <= '0;
								state_q  <= S_RESP;
							end else begin
								pos_q   <= AW'(lt_q);
								rkey_q  <= key_q;
								state_q <= S_SHIFT;
							end
						end
						skt_pkg::OP_LOAD: begin
							pos_q   <= AW'(le_q);
							rkey_q  <= key_q;
							state_q <= S_SHIFT;
						end
						default: begin
							pos_q   <= AW'(idx_q);
							state_q <= S_RESP;
						end
					endcase
				end
				S_SEARCH: begin
					if (lo_q >= hi_q) begin
						status_q <= skt_pkg::ST_MISS;
						state_q  <= S_RESP;
					end else if (mid < lt_q) begin
						lo_q <= mid + 1'b1;
					end else if (mid >= le_q) begin
						hi_q <= mid;
					end else begin
						pos_q   <= AW'(mid);
						rkey_q  <= key_q;
						state_q <= (op_q == skt_pkg::OP_REMOVE) ? S_SHIFT : S_RESP;
					end
				end
				S_SHIFT: begin
					if (op_q == skt_pkg::OP_REMOVE) begin
						count_q <= count_q - 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!res_valid_q || res_ready) begin
						res_q.status      <= status_q;
						res_q.position    <= (status_q == skt_pkg::ST_OK) ? 8'(pos_q) : 8'd0;
						res_q.key_out     <= rkey_q;
						res_q.entry_total <= 9'(count_q);
						res_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_scan_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |=> $stable(count_q))
		else $error("entry count changed during scan");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> (lt_q <= le_q) && (le_q <= count_q) && (lo_q <= hi_q))
		else $error("search bounds inconsistent");

	a_shift_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) && (op_q != skt_pkg::OP_REMOVE) |-> count_q < CAP_C)
		else $error("insert shift into a full table");
`endif

endmodule

>>> hw/rtl/sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_table_top: sorted table of 64-bit credential keys
// Ring of key cells with a sequencer for lookup, insert, remove, read, clear
// and load.
// ----------------------------------------------------------------------------
// The keys sit in a ring of CAPACITY cells, kept in ascending order. Lookup,
// insert, remove, load and an in-range read each rotate the ring once around
// while the head cell is compared against the key; a lookup or remove then
// replays the binary search, and an insert, load or remove that goes ahead
// shifts the cells. Clear, an unknown opcode and requests refused at once
// (zero key, full table, read out of range) go straight to the response
// without a scan. One request is in work at a time; a finished result waits
// in the output register without holding up the next request.
module sorted_key_table_top #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  skt_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output skt_pkg::res_t res
);

	localparam int AW = $clog2(CAPACITY);

	skt_pkg::cell_cmd_t        cmd;
	logic [AW-1:0]             cmd_pos;
	logic [skt_pkg::KEY_W-1:0] cell_key [CAPACITY];

	skt_ctrl #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.head_key (cell_key[0]),
		.cmd      (cmd),
		.cmd_pos  (cmd_pos)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skt_cell #(
			.CAPACITY(CAPACITY),
			.INDEX   (i),
			.AW      (AW)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.pos      (cmd_pos),
			.left_key (cell_key[(i + CAPACITY - 1) % CAPACITY]),
			.right_key(cell_key[(i + 1) % CAPACITY]),
			.key      (cell_key[i])
		);
	end

endmodule

>>> bench/tb_sorted_key_table_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_table_top: self-checking bench for the sorted key table
// A queue-fed driver sends lookup, insert, remove, read, clear and load
// requests with bursty gaps while the result side stalls on its own pattern.
// Each accepted request runs through a sorted-array model of the table, and
// every result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_key_table_top;

	localparam int TABLE_DEPTH = skt_pkg::CAPACITY_DEF;
	localparam int IDLE_LIMIT  = 8000;
	localparam int TAIL_CYCLES = TABLE_DEPTH + 40;
	localparam int POOL_SIZE   = 48;

	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;

	localparam logic [skt_pkg::KEY_W-1:0] KEY_ZERO = '0;
	localparam logic [skt_pkg::KEY_W-1:0] KEY_ONES = '1;
	localparam logic [skt_pkg::KEY_W-1:0] KEY_TOP  = {1'b1, {(skt_pkg::KEY_W-1){1'b0}}};
	localparam logic [skt_pkg::KEY_W-1:0] KEY_MID  = {1'b0, {(skt_pkg::KEY_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	skt_pkg::req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	skt_pkg::res_t res;

	skt_pkg::req_t request_backlog[$];
	skt_pkg::res_t pending_answers[$];
	logic [skt_pkg::KEY_W-1:0] held_keys [TABLE_DEPTH];
	int unsigned held_count = 0;
	logic [skt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

	bit req_pending = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned ready_hold = 0;
	int unsigned requests_taken = 0;
	int unsigned requests_total = 0;
	int unsigned idle_cycles = 0;
	int unsigned mismatches = 0;

	sorted_key_table_top #(
		.CAPACITY(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always #4 clk = ~clk;

	function automatic bit find_key(input logic [skt_pkg::KEY_W-1:0] k,
			output int unsigned at);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = held_count;
		at = 0;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (held_keys[mid] == k) begin
				at = mid;
				return 1'b1;
			end
			if (held_keys[mid] < k) lo = mid + 1;
			else hi = mid;
		end
		return 1'b0;
	endfunction

	// Applies one request to the table image and returns the answer it gives.
	function automatic skt_pkg::res_t table_apply(input skt_pkg::req_t r);
		skt_pkg::res_t o;
		int unsigned at;
		int unsigned p;
		o = '0;
		o.status = skt_pkg::ST_OK;
		case (r.opcode)
			skt_pkg::OP_LOOKUP, skt_pkg::OP_INSERT, skt_pkg::OP_REMOVE,
			skt_pkg::OP_LOAD: begin
				if (r.key == KEY_ZERO) begin
					o.status = skt_pkg::ST_BAD;
				end else if (r.opcode == skt_pkg::OP_LOOKUP) begin
					if (find_key(r.key, at)) begin
						o.position = at[7:0];
						o.key_out = r.key;
					end else begin
						o.status = skt_pkg::ST_MISS;
					end
				end else if (r.opcode == skt_pkg::OP_REMOVE) begin
					if (find_key(r.key, at)) begin
						for (int unsigned i = at; i + 1 < held_count; i++)
							held_keys[i] = held_keys[i + 1];
						held_count--;
						o.position = at[7:0];
						o.key_out = r.key;
					end else begin
						o.status = skt_pkg::ST_MISS;
					end
				end else if (held_count >= TABLE_DEPTH) begin
					o.status = skt_pkg::ST_FULL;
				end else if (r.opcode == skt_pkg::OP_INSERT && find_key(r.key, at)) begin
					o.status = skt_pkg::ST_DUP;
				end else begin
					p = 0;
					while (p < held_count && (held_keys[p] < r.key ||
							(r.opcode == skt_pkg::OP_LOAD && held_keys[p] == r.key)))
						p++;
					for (int unsigned i = held_count; i > p; i--)
						held_keys[i] = held_keys[i - 1];
					held_keys[p] = r.key;
					held_count++;
					o.position = p[7:0];
					o.key_out = r.key;
				end
			end
			skt_pkg::OP_READ: begin
				if (r.index < held_count) begin
					o.position = r.index;
					o.key_out = held_keys[r.index];
				end else begin
					o.status = skt_pkg::ST_MISS;
				end
			end
			skt_pkg::OP_CLEAR: begin
				held_count = 0;
			end
			default: begin
				o.status = skt_pkg::ST_MISS;
			end
		endcase
		o.entry_total = held_count[8:0];
		return o;
	endfunction

	task automatic add_request(input logic [2:0] op, input logic [skt_pkg::KEY_W-1:0] k,
			input logic [7:0] ix);
		skt_pkg::req_t r;
		r.opcode = op;
		r.key = k;
		r.index = ix;
		request_backlog.push_back(r);
	endtask

	function automatic logic [skt_pkg::KEY_W-1:0] fresh_key();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 3) return KEY_ZERO;
		if (roll < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (roll < 95) return fresh_key();
		case ($urandom_range(0, 3))
			0: return KEY_ONES;
			1: return KEY_TOP;
			2: return KEY_MID;
			default: return 64'd1;
		endcase
	endfunction

	function automatic logic [7:0] pick_index();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 40));
	endfunction

	function automatic logic [2:0] pick_opcode();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 20) return skt_pkg::OP_LOOKUP;
		if (roll < 50) return skt_pkg::OP_INSERT;
		if (roll < 70) return skt_pkg::OP_REMOVE;
		if (roll < 86) return skt_pkg::OP_READ;
		if (roll < 95) return skt_pkg::OP_LOAD;
		if (roll < 97) return skt_pkg::OP_CLEAR;
		if (roll < 98) return OP_RSVD_6;
		return OP_RSVD_7;
	endfunction

	task automatic add_mixed(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			add_request(pick_opcode(), pick_key(), 8'($urandom_range(0, 255)));
	endtask

	// Request driver: bursts of back-to-back requests separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_pending) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (request_backlog.size() > 0) begin
				req <= request_backlog.pop_front();
				req_valid <= 1'b1;
				req_pending = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: gap_left = 0;
						5, 6, 7: gap_left = $urandom_range(1, 8);
						default: gap_left = $urandom_range(1, 300);
					endcase
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side stalls on its own schedule, including long open stretches.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					res_ready <= 1'b1;
					ready_hold = $urandom_range(0, 40);
				end
				5, 6, 7: begin
					res_ready <= 1'b0;
					ready_hold = $urandom_range(0, 3);
				end
				8: begin
					res_ready <= 1'b0;
					ready_hold = $urandom_range(20, 400);
				end
				default: begin
					res_ready <= 1'b1;
					ready_hold = $urandom_range(200, 600);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			pending_answers.push_back(table_apply(req));
			requests_taken++;
			req_pending = 1'b0;
		end
	end

	always @(posedge clk) begin
		skt_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_answers.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (res.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res.status);
					mismatches++;
				end
				if (res.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, res.position);
					mismatches++;
				end
				if (res.key_out !== want.key_out) begin
					$error("key_out: expected %h, got %h", want.key_out, res.key_out);
					mismatches++;
				end
				if (res.entry_total !== want.entry_total) begin
					$error("entry_total: expected %0d, got %0d", want.entry_total,
						res.entry_total);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = fresh_key();
		key_pool[0] = 64'd1;
		key_pool[1] = KEY_ONES;
		key_pool[2] = KEY_TOP;
		key_pool[3] = KEY_MID;
		key_pool[4] = KEY_TOP | 64'd1;

		// Empty table, zero keys, ordering across the sign bit, duplicates.
		add_request(skt_pkg::OP_LOOKUP, KEY_ZERO, 8'd0);
		add_request(skt_pkg::OP_READ, KEY_ZERO, 8'd0);
		add_request(skt_pkg::OP_REMOVE, 64'd5, 8'd0);
		add_request(skt_pkg::OP_INSERT, KEY_ZERO, 8'd0);
		add_request(skt_pkg::OP_LOAD, KEY_ZERO, 8'd0);
		add_request(skt_pkg::OP_INSERT, KEY_ONES, 8'd0);
		add_request(skt_pkg::OP_INSERT, 64'd1, 8'd0);
		add_request(skt_pkg::OP_INSERT, KEY_TOP, 8'd0);
		add_request(skt_pkg::OP_INSERT, KEY_MID, 8'd0);
		add_request(skt_pkg::OP_INSERT, 64'd1, 8'd0);
		add_request(skt_pkg::OP_LOAD, KEY_TOP, 8'd0);
		add_request(skt_pkg::OP_LOOKUP, KEY_TOP, 8'd0);
		add_request(skt_pkg::OP_LOOKUP, KEY_ONES, 8'd0);
		add_request(skt_pkg::OP_LOOKUP, 64'd2, 8'd0);
		add_request(skt_pkg::OP_READ, KEY_ZERO, 8'd4);
		add_request(skt_pkg::OP_READ, KEY_ZERO, 8'd5);
		add_request(skt_pkg::OP_READ, KEY_ONES, 8'd255);
		add_request(OP_RSVD_6, KEY_ONES, 8'd255);
		add_request(OP_RSVD_7, KEY_ONES, 8'd255);
		add_request(skt_pkg::OP_REMOVE, KEY_TOP, 8'd0);
		add_request(skt_pkg::OP_REMOVE, 64'd1, 8'd0);
		add_request(skt_pkg::OP_CLEAR, KEY_ONES, 8'd0);
		add_request(skt_pkg::OP_LOOKUP, KEY_ONES, 8'd0);

		add_mixed(380);

		// Fill the table to capacity, probe it while full, then drain part of it.
		add_request(skt_pkg::OP_CLEAR, KEY_ZERO, 8'd0);
		for (int i = 0; i < 270; i++)
			add_request($urandom_range(0, 2) == 0 ? skt_pkg::OP_INSERT : skt_pkg::OP_LOAD,
				$urandom_range(0, 1) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
					: fresh_key(), 8'($urandom_range(0, 255)));
		for (int i = 0; i < 8; i++)
			add_request(skt_pkg::OP_INSERT,
				$urandom_range(0, 1) ? key_pool[i] : fresh_key(), 8'd0);
		for (int i = 0; i < 4; i++)
			add_request(skt_pkg::OP_LOAD, fresh_key(), 8'd0);
		add_request(skt_pkg::OP_INSERT, KEY_ZERO, 8'd0);
		add_request(skt_pkg::OP_LOAD, KEY_ZERO, 8'd0);
		add_request(skt_pkg::OP_READ, KEY_ZERO, 8'd255);
		add_request(skt_pkg::OP_READ, KEY_ZERO, 8'd0);
		for (int i = 0; i < 30; i++)
			add_request(skt_pkg::OP_READ, fresh_key(), 8'($urandom_range(0, 255)));
		for (int i = 0; i < 30; i++)
			add_request(skt_pkg::OP_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)],
				8'd0);
		for (int i = 0; i < 80; i++)
			add_request($urandom_range(0, 4) == 0 ? skt_pkg::OP_READ : skt_pkg::OP_REMOVE,
				key_pool[$urandom_range(0, POOL_SIZE - 1)], pick_index());

		add_mixed(270);
		requests_total = request_backlog.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (requests_taken < requests_total) @(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
